@@ rtl/ppts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppts_pkg
// Shared widths, constants and types for the point projection pipeline.
// ----------------------------------------------------------------------------
package ppts_pkg;

    localparam int DIR_W     = 16;
    localparam int P_W       = 30;
    localparam int M_W       = 32;
    localparam int PROD_W    = P_W + M_W;
    localparam int CLIP_W    = 64;
    localparam int Q_W       = 32;
    localparam int FRAC_W    = 16;
    localparam int DIV_W     = 62;
    localparam int DIV_STEPS = Q_W;
    localparam int DIV_LAT   = DIV_STEPS + 3;
    localparam int NUM_REGS  = 8;
    localparam int IDX_W     = 3;
    localparam int REG_W     = 64;
    localparam int BIAS_SH   = 14;

    localparam logic signed [P_W-1:0] FAR_DIST  = P_W'(10000);
    localparam logic [CLIP_W-1:0]      W_EPS     = CLIP_W'(107374);
    localparam logic [Q_W-1:0]         Q16_HALF  = Q_W'(32'h0000_8000);
    localparam logic [Q_W-1:0]         Q16_M_ONE = Q_W'(32'hFFFF_0000);
    localparam logic [Q_W:0]           LIM_POS   = {2'b00, {(Q_W-1){1'b1}}};
    localparam logic [Q_W:0]           LIM_NEG   = {2'b01, {(Q_W-1){1'b0}}};

    typedef struct packed {
        logic           sat;
        logic [Q_W-1:0] quo;
    } div_res_t;

endpackage

@@ rtl/ppts_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppts_div
// Pipelined restoring divider: magnitude ratio as Q16.16, one quotient bit
// per stage, round half away from zero, signed saturation.
// ----------------------------------------------------------------------------
module ppts_div (
    input  logic                     clk,
    input  logic                     en,
    input  logic [ppts_pkg::DIV_W-1:0] num,
    input  logic [ppts_pkg::DIV_W-1:0] den,
    input  logic                     neg,
    output ppts_pkg::div_res_t       res
);

    localparam int DW = ppts_pkg::DIV_W;
    localparam int QW = ppts_pkg::Q_W;
    localparam int FW = ppts_pkg::FRAC_W;
    localparam int NS = ppts_pkg::DIV_STEPS;

    logic [DW-1:0] rem_reg  [0:NS];
    logic [DW-1:0] rem_next [0:NS];
    logic [DW-1:0] den_reg  [0:NS];
    logic [FW-1:0] low_reg  [0:NS];
    logic [FW-1:0] low_next [0:NS];
    logic [QW-1:0] quo_reg  [0:NS];
    logic [QW-1:0] quo_next [0:NS];
    logic          neg_reg  [0:NS];
    logic          ovf_reg  [0:NS];
    logic          ovf_next;

    logic [QW:0]   q33_reg;
    logic [QW:0]   q33_next;
    logic          rneg_reg;
    logic          rovf_reg;

    ppts_pkg::div_res_t res_reg;
    ppts_pkg::div_res_t res_next;

    always_comb
    begin
        logic [DW:0] trial;
        rem_next[0] = DW'(num >> FW);
        low_next[0] = num[FW-1:0];
        quo_next[0] = '0;
        ovf_next    = (DW'(num >> FW) >= den);
        for (int k = 0; k < NS; k++)
        begin
            trial = {rem_reg[k], low_reg[k][FW-1]};
            if (trial >= {1'b0, den_reg[k]})
            begin
                rem_next[k+1] = DW'(trial - {1'b0, den_reg[k]});
                quo_next[k+1] = quo_reg[k] | (QW'(1) << (QW - 1 - k));
            end
            else
            begin
                rem_next[k+1] = trial[DW-1:0];
                quo_next[k+1] = quo_reg[k];
            end
            low_next[k+1] = {low_reg[k][FW-2:0], 1'b0};
        end
    end

    always_comb
    begin
        logic            rnd;
        rnd      = ({rem_reg[NS], 1'b0} >= {1'b0, den_reg[NS]});
        q33_next = {1'b0, quo_reg[NS]} + (QW+1)'(rnd);
    end

    always_comb
    begin
        logic [QW:0] limit;
        logic [QW:0] qm;
        limit = rneg_reg ? ppts_pkg::LIM_NEG : ppts_pkg::LIM_POS;
        if (rovf_reg || (q33_reg > limit))
        begin
            qm           = limit;
            res_next.sat = 1'b1;
        end
        else
        begin
            qm           = q33_reg;
            res_next.sat = 1'b0;
        end
        res_next.quo = rneg_reg ? (QW'(0) - qm[QW-1:0]) : qm[QW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= rem_next[0];
            den_reg[0] <= den;
            low_reg[0] <= low_next[0];
            quo_reg[0] <= quo_next[0];
            neg_reg[0] <= neg;
            ovf_reg[0] <= ovf_next;
            for (int k = 0; k < NS; k++)
            begin
                rem_reg[k+1] <= rem_next[k+1];
                den_reg[k+1] <= den_reg[k];
                low_reg[k+1] <= low_next[k+1];
                quo_reg[k+1] <= quo_next[k+1];
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
            q33_reg  <= q33_next;
            rneg_reg <= neg_reg[NS];
            rovf_reg <= ovf_reg[NS];
            res_reg  <= res_next;
        end
    end

    assign res = res_reg;

endmodule

@@ rtl/point_projection_to_screen_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_projection_to_screen_top
// Direction to screen UV and depth: 4x4 view-projection transform, divide by clip w.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle; a stalled output holds every stage in place.
// Depth set by the divider, one quotient bit per stage (32 of 35 stages).
// Reset: asynchronous, clears all valid bits and the matrix registers to zero.
// ----------------------------------------------------------------------------
module point_projection_to_screen_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [47:0]                     s_tdata,   // dir_x, dir_y, dir_z
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [95:0]                     m_tdata,   // screen_u, screen_v, depth
    output logic [0:0]                      m_tuser,   // saturated
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ppts_pkg::IDX_W-1:0]      cfg_index,
    input  logic [ppts_pkg::REG_W-1:0]      cfg_data
);

    localparam int DW  = ppts_pkg::DIV_W;
    localparam int CW  = ppts_pkg::CLIP_W;
    localparam int QW  = ppts_pkg::Q_W;
    localparam int PW  = ppts_pkg::P_W;
    localparam int MW  = ppts_pkg::M_W;
    localparam int PRW = ppts_pkg::PROD_W;
    localparam int DL  = ppts_pkg::DIV_LAT;
    localparam int NW  = ppts_pkg::DIR_W;

    typedef struct packed {
        logic degen;
        logic wneg;
    } side_t;

    logic                en;
    logic [ppts_pkg::REG_W-1:0] vp_reg [ppts_pkg::NUM_REGS];
    logic signed [MW-1:0] mat [4][4];

    logic                 vld1_reg;
    logic signed [PW-1:0] p_reg [3];
    logic                 vld2_reg;
    logic signed [PRW-1:0] prod_reg [4][3];
    logic                 vld3_reg;
    logic signed [CW-1:0] clip_reg [4];
    logic                 vld4_reg;
    logic signed [CW-1:0] sx_reg;
    logic signed [CW-1:0] sy_reg;
    logic signed [CW-1:0] z_reg;
    logic signed [CW-1:0] w_reg;

    logic [CW-1:0]        mag_sx;
    logic [CW-1:0]        mag_sy;
    logic [CW-1:0]        mag_z;
    logic [CW-1:0]        mag_w;

    logic                 vld5_reg;
    logic [DW-1:0]        nu_reg;
    logic [DW-1:0]        nv_reg;
    logic [DW-1:0]        nz_reg;
    logic [DW-1:0]        du_reg;
    logic [DW-1:0]        dz_reg;
    logic                 negu_reg;
    logic                 negv_reg;
    logic                 negz_reg;
    side_t                side5_reg;

    logic                 vldd_reg  [DL];
    side_t                side_reg  [DL];

    ppts_pkg::div_res_t   res_u;
    ppts_pkg::div_res_t   res_v;
    ppts_pkg::div_res_t   res_z;

    logic                 out_vld_reg;
    logic [QW-1:0]        u_reg;
    logic [QW-1:0]        v_reg;
    logic [QW-1:0]        depth_reg;
    logic                 sat_reg;
    logic [QW-1:0]        u_next;
    logic [QW-1:0]        v_next;
    logic [QW-1:0]        depth_next;
    logic                 sat_next;

    assign en        = !out_vld_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ppts_pkg::NUM_REGS; i++)
            begin
                vp_reg[i] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            vp_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int h = 0; h < 2; h++)
            begin
                for (int k = 0; k < 2; k++)
                begin
                    mat[r][2*h+k] = vp_reg[2*r+h][MW*k +: MW];
                end
            end
        end
    end

    assign mag_sx = sx_reg[CW-1] ? (CW'(0) - sx_reg) : sx_reg;
    assign mag_sy = sy_reg[CW-1] ? (CW'(0) - sy_reg) : sy_reg;
    assign mag_z  = z_reg[CW-1]  ? (CW'(0) - z_reg)  : z_reg;
    assign mag_w  = w_reg[CW-1]  ? (CW'(0) - w_reg)  : w_reg;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg    <= 1'b0;
            vld2_reg    <= 1'b0;
            vld3_reg    <= 1'b0;
            vld4_reg    <= 1'b0;
            vld5_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int i = 0; i < DL; i++)
            begin
                vldd_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld1_reg    <= s_tvalid;
            vld2_reg    <= vld1_reg;
            vld3_reg    <= vld2_reg;
            vld4_reg    <= vld3_reg;
            vld5_reg    <= vld4_reg;
            vldd_reg[0] <= vld5_reg;
            for (int i = 1; i < DL; i++)
            begin
                vldd_reg[i] <= vldd_reg[i-1];
            end
            out_vld_reg <= vldd_reg[DL-1];
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                p_reg[j] <= PW'($signed(s_tdata[NW*j +: NW])) * ppts_pkg::FAR_DIST;
            end
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[i][j] <= PRW'(mat[i][j]) * PRW'(p_reg[j]);
                end
            end
            for (int i = 0; i < 4; i++)
            begin
                clip_reg[i] <= CW'(prod_reg[i][0]) + CW'(prod_reg[i][1])
                             + CW'(prod_reg[i][2])
                             + (CW'(mat[i][3]) <<< ppts_pkg::BIAS_SH);
            end
            sx_reg <= clip_reg[3] + clip_reg[0];
            sy_reg <= clip_reg[3] - clip_reg[1];
            z_reg  <= clip_reg[2];
            w_reg  <= clip_reg[3];

            nu_reg          <= mag_sx[DW-1:0];
            nv_reg          <= mag_sy[DW-1:0];
            nz_reg          <= mag_z[DW-1:0];
            du_reg          <= {mag_w[DW-2:0], 1'b0};
            dz_reg          <= mag_w[DW-1:0];
            negu_reg        <= sx_reg[CW-1] ^ w_reg[CW-1];
            negv_reg        <= sy_reg[CW-1] ^ w_reg[CW-1];
            negz_reg        <= z_reg[CW-1] ^ w_reg[CW-1];
            side5_reg.degen <= (mag_w <= ppts_pkg::W_EPS);
            side5_reg.wneg  <= w_reg[CW-1];

            side_reg[0] <= side5_reg;
            for (int i = 1; i < DL; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end

            u_reg     <= u_next;
            v_reg     <= v_next;
            depth_reg <= depth_next;
            sat_reg   <= sat_next;
        end
    end

    ppts_div u_div_u (
        .clk (clk),
        .en  (en),
        .num (nu_reg),
        .den (du_reg),
        .neg (negu_reg),
        .res (res_u)
    );

    ppts_div u_div_v (
        .clk (clk),
        .en  (en),
        .num (nv_reg),
        .den (du_reg),
        .neg (negv_reg),
        .res (res_v)
    );

    ppts_div u_div_z (
        .clk (clk),
        .en  (en),
        .num (nz_reg),
        .den (dz_reg),
        .neg (negz_reg),
        .res (res_z)
    );

    always_comb
    begin
        if (side_reg[DL-1].degen)
        begin
            u_next     = ppts_pkg::Q16_HALF;
            v_next     = ppts_pkg::Q16_HALF;
            depth_next = ppts_pkg::Q16_M_ONE;
            sat_next   = 1'b0;
        end
        else
        begin
            u_next     = res_u.quo;
            v_next     = res_v.quo;
            depth_next = side_reg[DL-1].wneg ? ppts_pkg::Q16_M_ONE : res_z.quo;
            sat_next   = res_u.sat | res_v.sat | (!side_reg[DL-1].wneg & res_z.sat);
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {depth_reg, v_reg, u_reg};
    assign m_tuser  = sat_reg;

endmodule
